// ----- rtl/vdu_pkg.sv -----
package vdu_pkg;

    // accumulator and result format, Q.24 in 48 bits
    localparam int ACC_W  = 48;
    localparam int THR_W  = 25;
    localparam int NORM_W = 36;
    localparam int PROD_W = 72;
    localparam int REM_W  = 74;
    localparam int CNT_W  = 7;

    localparam logic [ACC_W-1:0] ACC_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [ACC_W-1:0] ACC_MIN = 48'h8000_0000_0000;
    localparam logic [ACC_W-1:0] ONE_Q24 = 48'h0000_0100_0000;
    localparam logic [ACC_W-1:0] COS_CAP = 48'h8000_0000_0000;

    localparam logic [CNT_W-1:0] SQRT_LAST = 7'd35;
    localparam logic [CNT_W-1:0] MUL_LAST  = 7'd35;
    localparam logic [CNT_W-1:0] DIV_LAST  = 7'd95;

    typedef enum logic [1:0] {
        METRIC_L2SQ    = 2'd0,
        METRIC_IP      = 2'd1,
        METRIC_L2_NORM = 2'd2,
        METRIC_COSINE  = 2'd3
    } metric_t;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_OVF  = 2'd1;
    localparam logic [1:0] STATUS_ZERO = 2'd2;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = THR_W;
    localparam logic [CFG_IDX_W-1:0] REG_METRIC_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_THR    = 1'b1;

    typedef struct packed {
        logic signed [ACC_W-1:0] dot;
        logic signed [ACC_W-1:0] diff;
        logic signed [ACC_W-1:0] norm_a;
        logic signed [ACC_W-1:0] norm_b;
        logic                    ovf;
    } vdu_sums_t;

endpackage

// ----- rtl/vdu_if.sv -----
interface vdu_in_if #(
    parameter int ELEM_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [ELEM_WIDTH-1:0] elem_a;
    logic signed [ELEM_WIDTH-1:0] elem_b;
    logic                         last;

    modport source (output valid, output elem_a, output elem_b, output last, input ready);
    modport sink   (input valid, input elem_a, input elem_b, input last, output ready);
endinterface

interface vdu_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] distance;
    logic [1:0]         status;

    modport source (output valid, output distance, output status, input ready);
    modport sink   (input valid, input distance, input status, output ready);
endinterface

// ----- rtl/vdu_accum.sv -----
module vdu_accum
    import vdu_pkg::*;
#(
    parameter int MAX_LENGTH = 4096,
    parameter int ELEM_WIDTH = 16
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [ELEM_WIDTH-1:0] elem_a,
    input  logic signed [ELEM_WIDTH-1:0] elem_b,
    input  logic                         last,
    output logic                         hand_valid,
    input  logic                         hand_ready,
    output vdu_sums_t                    sums
);

    localparam int LEN_W = $clog2(MAX_LENGTH + 1);
    localparam int OP_W  = ELEM_WIDTH + 1;
    localparam int PW    = 2 * OP_W;
    localparam int SW    = (PW + 1 > ACC_W + 1) ? PW + 1 : ACC_W + 1;

    typedef enum logic [1:0] {A_IDLE, A_RUN, A_HAND} state_t;

    state_t                   state_reg;
    logic [2:0]               step_reg;
    logic signed [ELEM_WIDTH-1:0] a_reg;
    logic signed [ELEM_WIDTH-1:0] b_reg;
    logic                     last_reg;
    logic signed [PW-1:0]     prod_reg;
    logic signed [ACC_W-1:0]  acc_reg [4];
    logic [LEN_W-1:0]         count_reg;
    logic                     ovf_reg;

    logic signed [OP_W-1:0]   a_x, b_x, d_x, op_x, op_y;
    logic signed [PW-1:0]     mul_p;
    logic [1:0]               acc_idx;
    logic signed [ACC_W-1:0]  acc_cur;
    logic signed [SW-1:0]     sum_w;
    logic signed [ACC_W-1:0]  sat_val;
    logic                     sat_hit;

    // select the product of this step: a*b, d*d, a*a, b*b
    always_comb
    begin
        a_x = {a_reg[ELEM_WIDTH-1], a_reg};
        b_x = {b_reg[ELEM_WIDTH-1], b_reg};
        d_x = a_x - b_x;
        case (step_reg[1:0])
            2'd0:    begin op_x = a_x; op_y = b_x; end
            2'd1:    begin op_x = d_x; op_y = d_x; end
            2'd2:    begin op_x = a_x; op_y = a_x; end
            default: begin op_x = b_x; op_y = b_x; end
        endcase
        mul_p = op_x * op_y;
    end

    // saturating add of the registered product into its accumulator
    always_comb
    begin
        acc_idx = 2'(step_reg - 3'd1);
        acc_cur = acc_reg[acc_idx];
        sum_w   = {{(SW-ACC_W){acc_cur[ACC_W-1]}}, acc_cur}
                + {{(SW-PW){prod_reg[PW-1]}}, prod_reg};
        sat_hit = 1'b1;
        if (sum_w > $signed({{(SW-ACC_W){1'b0}}, ACC_MAX}))
            sat_val = ACC_MAX;
        else if (sum_w < $signed({{(SW-ACC_W){1'b1}}, ACC_MIN}))
            sat_val = ACC_MIN;
        else
        begin
            sat_val = sum_w[ACC_W-1:0];
            sat_hit = 1'b0;
        end
    end

    assign in_ready   = (state_reg == A_IDLE);
    assign hand_valid = (state_reg == A_HAND);
    assign sums       = '{dot: acc_reg[0], diff: acc_reg[1], norm_a: acc_reg[2],
                          norm_b: acc_reg[3], ovf: ovf_reg};

    // sequencer: one multiply per cycle, each product added from its register in the next cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            step_reg  <= '0;
            last_reg  <= 1'b0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            for (int i = 0; i < 4; i++)
                acc_reg[i] <= '0;
        end
        else
        begin
            case (state_reg)
                A_IDLE:
                begin
                    if (in_valid)
                    begin
                        a_reg    <= elem_a;
                        b_reg    <= elem_b;
                        last_reg <= last;
                        step_reg <= '0;
                        if (count_reg == LEN_W'(MAX_LENGTH))
                        begin
                            ovf_reg   <= 1'b1;
                            state_reg <= last ? A_HAND : A_IDLE;
                        end
                        else
                            state_reg <= A_RUN;
                    end
                end
                A_RUN:
                begin
                    if (step_reg != 3'd4)
                        prod_reg <= mul_p;
                    if (step_reg != 3'd0)
                    begin
                        acc_reg[acc_idx] <= sat_val;
                        if (sat_hit)
                            ovf_reg <= 1'b1;
                    end
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == 3'd4)
                    begin
                        count_reg <= count_reg + 1'b1;
                        state_reg <= last_reg ? A_HAND : A_IDLE;
                    end
                end
                A_HAND:
                begin
                    // pass the sums on, then clear for the next vector
                    if (hand_ready)
                    begin
                        for (int i = 0; i < 4; i++)
                            acc_reg[i] <= '0;
                        count_reg <= '0;
                        ovf_reg   <= 1'b0;
                        state_reg <= A_IDLE;
                    end
                end
                default:
                    state_reg <= A_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/vdu_finish.sv -----
module vdu_finish
    import vdu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               hand_valid,
    output logic               hand_ready,
    input  vdu_sums_t          sums,
    input  metric_t            metric_mode,
    input  logic [THR_W-1:0]   zero_thr,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [ACC_W-1:0] distance,
    output logic [1:0]         status
);

    typedef enum logic [3:0] {
        F_IDLE, F_EVAL, F_SQRT_A, F_SQRT_B, F_ZCHK, F_MUL, F_DIV, F_FINAL, F_DONE
    } state_t;

    state_t              state_reg;
    vdu_sums_t           sums_reg;
    logic [ACC_W-1:0]    work_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [ACC_W-1:0]    res_reg;
    logic                big_reg;
    logic [NORM_W-1:0]   na_reg;
    logic [NORM_W-1:0]   nb_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic signed [ACC_W-1:0] dist_reg;
    logic [1:0]          status_reg;

    logic [REM_W-1:0]    opa, opb;
    logic                sub;
    logic [REM_W:0]      add_w;
    logic [REM_W-1:0]    add_sum;
    logic                ge;
    logic [ACC_W-1:0]    res_step;
    logic                zero_l2, zero_cos;
    logic signed [50:0]  l2_w;
    logic [ACC_W-1:0]    qc;
    logic signed [48:0]  cos_w;
    logic signed [50:0]  fin_w;
    logic [48:0]         l2_sat, fin_sat;
    logic [ACC_W-1:0]    mag;

    // clamp a wide signed value to the accumulator range, flag in the top bit
    function automatic logic [48:0] sat_acc(input logic signed [50:0] v);
        logic [48:0] r;
        if (v > $signed({3'b000, ACC_MAX}))
            r = {1'b1, ACC_MAX};
        else if (v < $signed({3'b111, ACC_MIN}))
            r = {1'b1, ACC_MIN};
        else
            r = {1'b0, v[ACC_W-1:0]};
        return r;
    endfunction

    // shared add/compare-subtract unit for square root, product and division
    always_comb
    begin
        opa = '0;
        opb = '0;
        sub = 1'b0;
        case (state_reg)
            F_SQRT_A, F_SQRT_B:
            begin
                opa = {rem_reg[REM_W-3:0], work_reg[ACC_W-1:ACC_W-2]};
                opb = {{(REM_W-ACC_W-2){1'b0}}, res_reg, 2'b01};
                sub = 1'b1;
            end
            F_MUL:
            begin
                opa = {rem_reg[REM_W-2:0], 1'b0};
                opb = nb_reg[NORM_W-1] ? {{(REM_W-NORM_W){1'b0}}, na_reg} : '0;
            end
            F_DIV:
            begin
                opa = {rem_reg[REM_W-2:0], work_reg[ACC_W-1]};
                opb = {{(REM_W-PROD_W){1'b0}}, prod_reg};
                sub = 1'b1;
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
        add_w    = {1'b0, opa} + {1'b0, (sub ? ~opb : opb)} + {{REM_W{1'b0}}, sub};
        add_sum  = add_w[REM_W-1:0];
        ge       = add_w[REM_W];
        res_step = {res_reg[ACC_W-2:0], ge};
    end

    // final arithmetic of the metrics
    always_comb
    begin
        zero_l2  = ({1'b0, sums_reg.norm_a} < {24'd0, zero_thr})
                || ({1'b0, sums_reg.norm_b} < {24'd0, zero_thr});
        zero_cos = ({1'b0, na_reg} < {12'd0, zero_thr})
                || ({1'b0, nb_reg} < {12'd0, zero_thr})
                || (na_reg == '0) || (nb_reg == '0);
        l2_w = {{3{sums_reg.norm_a[ACC_W-1]}}, sums_reg.norm_a}
             + {{3{sums_reg.norm_b[ACC_W-1]}}, sums_reg.norm_b}
             - {{2{sums_reg.dot[ACC_W-1]}}, sums_reg.dot, 1'b0};
        l2_sat = sat_acc(l2_w);
        mag = sums_reg.dot[ACC_W-1] ? ACC_W'(-sums_reg.dot) : sums_reg.dot;
        qc = (big_reg || (res_reg[ACC_W-1] && (res_reg[ACC_W-2:0] != '0)))
           ? COS_CAP : res_reg;
        cos_w = sums_reg.dot[ACC_W-1] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
        fin_w = $signed({3'b000, ONE_Q24}) - {{2{cos_w[48]}}, cos_w};
        fin_sat = sat_acc(fin_w);
    end

    assign hand_ready = (state_reg == F_IDLE);
    assign out_valid  = (state_reg == F_DONE);
    assign distance   = dist_reg;
    assign status     = status_reg;

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            cnt_reg    <= '0;
            big_reg    <= 1'b0;
            status_reg <= STATUS_OK;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (hand_valid)
                    begin
                        sums_reg  <= sums;
                        state_reg <= F_EVAL;
                    end
                end
                F_EVAL:
                begin
                    case (metric_mode)
                        METRIC_L2SQ:
                        begin
                            dist_reg   <= sums_reg.diff;
                            status_reg <= sums_reg.ovf ? STATUS_OVF : STATUS_OK;
                            state_reg  <= F_DONE;
                        end
                        METRIC_IP:
                        begin
                            dist_reg   <= sums_reg.dot;
                            status_reg <= sums_reg.ovf ? STATUS_OVF : STATUS_OK;
                            state_reg  <= F_DONE;
                        end
                        METRIC_L2_NORM:
                        begin
                            if (zero_l2)
                            begin
                                dist_reg   <= '0;
                                status_reg <= sums_reg.ovf ? STATUS_OVF : STATUS_ZERO;
                            end
                            else
                            begin
                                dist_reg   <= l2_sat[ACC_W-1:0];
                                status_reg <= (sums_reg.ovf || l2_sat[ACC_W])
                                            ? STATUS_OVF : STATUS_OK;
                            end
                            state_reg <= F_DONE;
                        end
                        default:
                        begin
                            work_reg  <= sums_reg.norm_a[ACC_W-1] ? '0 : sums_reg.norm_a;
                            rem_reg   <= '0;
                            res_reg   <= '0;
                            cnt_reg   <= '0;
                            state_reg <= F_SQRT_A;
                        end
                    endcase
                end
                F_SQRT_A, F_SQRT_B:
                begin
                    // one root bit per cycle, two radicand bits in
                    rem_reg  <= ge ? add_sum : opa;
                    res_reg  <= res_step;
                    work_reg <= {work_reg[ACC_W-3:0], 2'b00};
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == SQRT_LAST)
                    begin
                        rem_reg <= '0;
                        res_reg <= '0;
                        cnt_reg <= '0;
                        if (state_reg == F_SQRT_A)
                        begin
                            na_reg    <= res_step[NORM_W-1:0];
                            work_reg  <= sums_reg.norm_b[ACC_W-1] ? '0 : sums_reg.norm_b;
                            state_reg <= F_SQRT_B;
                        end
                        else
                        begin
                            nb_reg    <= res_step[NORM_W-1:0];
                            state_reg <= F_ZCHK;
                        end
                    end
                end
                F_ZCHK:
                begin
                    if (zero_cos)
                    begin
                        dist_reg   <= '0;
                        status_reg <= sums_reg.ovf ? STATUS_OVF : STATUS_ZERO;
                        state_reg  <= F_DONE;
                    end
                    else
                    begin
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        work_reg  <= mag;
                        state_reg <= F_MUL;
                    end
                end
                F_MUL:
                begin
                    // shift-and-add product of the two norms
                    rem_reg <= add_sum;
                    nb_reg  <= {nb_reg[NORM_W-2:0], 1'b0};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == MUL_LAST)
                    begin
                        prod_reg  <= add_sum[PROD_W-1:0];
                        rem_reg   <= '0;
                        res_reg   <= '0;
                        big_reg   <= 1'b0;
                        cnt_reg   <= '0;
                        state_reg <= F_DIV;
                    end
                end
                F_DIV:
                begin
                    // restoring division, one quotient bit per cycle
                    rem_reg  <= ge ? add_sum : opa;
                    res_reg  <= res_step;
                    big_reg  <= big_reg | res_reg[ACC_W-1];
                    work_reg <= {work_reg[ACC_W-2:0], 1'b0};
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == DIV_LAST)
                        state_reg <= F_FINAL;
                end
                F_FINAL:
                begin
                    dist_reg   <= fin_sat[ACC_W-1:0];
                    status_reg <= (sums_reg.ovf || fin_sat[ACC_W]) ? STATUS_OVF : STATUS_OK;
                    state_reg  <= F_DONE;
                end
                F_DONE:
                begin
                    if (out_ready)
                        state_reg <= F_IDLE;
                end
                default:
                    state_reg <= F_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/vector_distance_unit.sv -----
// Vector distance unit.
// Input channel in_ch carries one element pair (elem_a, elem_b, Q3.12) per
// transaction, with last on the final pair of the vectors. Output channel
// out_ch carries one transaction per vector: distance (Q.24) and status
// (0 ok, 1 overflow or too long, 2 zero vector).
// Configuration: cfg_we writes cfg_data to register cfg_index (0 metric_mode,
// 1 zero_norm_threshold); write only while the unit is idle.
// Accumulator: one multiplier serves the four products of a pair, so a pair
// occupies it for its accept plus 5 multiply/add steps before the next one.
// Result: metrics 0 to 2 need one evaluation state after the handover; for
// cosine one shared adder runs two 36-step square roots, a 36-step norm
// product and a 96-step division, the last two skipped when a norm flags a
// zero vector. A last pair beyond the length limit skips the 5 accumulate
// steps.
// The accumulator keeps taking pairs of the next vector while the result
// stage works or waits. A stalled receiver holds the result; a further last
// pair then waits in the accumulator until the result stage is free.
// Reset clears the accumulators and sets metric_mode 0 and threshold 168.
module vector_distance_unit
    import vdu_pkg::*;
#(
    parameter int MAX_LENGTH = 4096,
    parameter int ELEM_WIDTH = 16
)(
    input  logic                  clk,
    input  logic                  rst_n,
    vdu_in_if.sink                in_ch,
    vdu_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    metric_t            metric_mode_reg;
    logic [THR_W-1:0]   zero_thr_reg;
    logic               hand_valid;
    logic               hand_ready;
    vdu_sums_t          sums;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            metric_mode_reg <= METRIC_L2SQ;
            zero_thr_reg    <= THR_W'(168);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_METRIC_MODE: metric_mode_reg <= metric_t'(cfg_data[1:0]);
                REG_ZERO_THR:    zero_thr_reg    <= cfg_data;
                default:         ;
            endcase
        end
    end

    vdu_accum #(
        .MAX_LENGTH (MAX_LENGTH),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_ready   (in_ch.ready),
        .elem_a     (in_ch.elem_a),
        .elem_b     (in_ch.elem_b),
        .last       (in_ch.last),
        .hand_valid (hand_valid),
        .hand_ready (hand_ready),
        .sums       (sums)
    );

    vdu_finish u_finish (
        .clk         (clk),
        .rst_n       (rst_n),
        .hand_valid  (hand_valid),
        .hand_ready  (hand_ready),
        .sums        (sums),
        .metric_mode (metric_mode_reg),
        .zero_thr    (zero_thr_reg),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .distance    (out_ch.distance),
        .status      (out_ch.status)
    );

`ifndef SYNTHESIS
    // a zero vector always reports a zero distance
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.status == STATUS_ZERO |-> out_ch.distance == '0)
        else $error("zero vector result with nonzero distance");

    // no status code beyond the defined three
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_ch.status != 2'd3)
        else $error("undefined status code");

    // direct metrics never flag a zero vector
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && (metric_mode_reg == METRIC_L2SQ || metric_mode_reg == METRIC_IP)
        |-> out_ch.status != STATUS_ZERO)
        else $error("zero vector flagged in a direct metric");

    // sums handed over only when the result stage takes them
    assert property (@(posedge clk) disable iff (!rst_n)
        hand_valid && hand_ready |=> !out_ch.valid)
        else $error("result stage busy while taking new sums");
`endif

endmodule

// ----- tb/vector_distance_unit_test.sv -----
module vector_distance_unit_test;
    import vdu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LEN = 4096;
    localparam logic signed [63:0] SAT_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] SAT_LO = -64'sh0000_8000_0000_0000;

    typedef struct {
        logic signed [47:0] distance;
        logic [1:0]         status;
    } vdu_result_t;

    typedef struct {
        bit                 typed;
        logic signed [47:0] distance;
        logic [1:0]         status;
    } typed_result_t;

    typedef struct {
        bit                 do_cfg;
        logic [0:0]         cfg_idx;
        logic [24:0]        cfg_val;
        logic signed [15:0] a;
        logic signed [15:0] b;
        bit                 last;
        bit                 typed;
        logic signed [47:0] distance;
        logic [1:0]         status;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    vdu_in_if #(.ELEM_WIDTH(16)) in_ch ();
    vdu_out_if out_ch ();

    vector_distance_unit #(
        .MAX_LENGTH(MAX_LEN),
        .ELEM_WIDTH(16)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // predictor state
    logic signed [63:0] dot_acc, diff_acc, sq_a_acc, sq_b_acc;
    int unsigned        pair_count;
    bit                 sticky_ovf;
    metric_t            metric_sel;
    logic [24:0]        zero_thr;

    vdu_result_t   distance_q[$];
    typed_result_t typed_q[$];
    int            errors;
    int            results_seen;
    int            items_sent;
    int            send_idle;
    int            recv_stall;
    int            stall_cycles;

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic signed [63:0] clamp48(input logic signed [63:0] v, inout bit f);
        if (v > SAT_HI)
        begin
            f = 1'b1;
            return SAT_HI;
        end
        if (v < SAT_LO)
        begin
            f = 1'b1;
            return SAT_LO;
        end
        return v;
    endfunction

    // floor square root of a Q.24 sum, giving a Q.24 norm
    function automatic logic [63:0] q24_root(input logic signed [63:0] s);
        logic [127:0] x;
        logic [63:0]  r;
        logic [63:0]  c;
        logic [127:0] cc;
        x = (s < 0) ? 128'd0 : ({64'd0, s} << 24);
        r = 64'd0;
        for (int k = 63; k >= 0; k--)
        begin
            c = r | (64'd1 << k);
            cc = {64'd0, c} * {64'd0, c};
            if (cc <= x)
                r = c;
        end
        return r;
    endfunction

    // accumulate one pair; return 1 with the distance when the vector closes
    function automatic bit accumulate_pair(input logic signed [15:0] a, input logic signed [15:0] b,
                                           input bit l, output vdu_result_t res);
        bit                 f;
        bit                 zero;
        logic signed [63:0] ea, eb, d, dist_val;
        logic [63:0]        na, nb, mag, qc;
        logic [127:0]       prod, num, q;
        logic signed [63:0] cosv;
        f = sticky_ovf;
        zero = 1'b0;
        dist_val = 64'sd0;
        res.distance = '0;
        res.status = STATUS_OK;
        if (pair_count >= MAX_LEN)
            f = 1'b1;
        else
        begin
            ea = a;
            eb = b;
            d = ea - eb;
            dot_acc = clamp48(dot_acc + ea * eb, f);
            diff_acc = clamp48(diff_acc + d * d, f);
            sq_a_acc = clamp48(sq_a_acc + ea * ea, f);
            sq_b_acc = clamp48(sq_b_acc + eb * eb, f);
            pair_count++;
        end
        sticky_ovf = f;
        if (!l)
            return 1'b0;
        case (metric_sel)
            METRIC_L2SQ: dist_val = diff_acc;
            METRIC_IP:   dist_val = dot_acc;
            METRIC_L2_NORM:
            begin
                if (sq_a_acc < $signed({39'd0, zero_thr}) || sq_b_acc < $signed({39'd0, zero_thr}))
                    zero = 1'b1;
                else
                    dist_val = clamp48(sq_a_acc + sq_b_acc - 2 * dot_acc, f);
            end
            default:
            begin
                na = q24_root(sq_a_acc);
                nb = q24_root(sq_b_acc);
                if (na < zero_thr || nb < zero_thr || na == 0 || nb == 0)
                    zero = 1'b1;
                else
                begin
                    prod = {64'd0, na} * {64'd0, nb};
                    mag = (dot_acc < 0) ? -dot_acc : dot_acc;
                    num = {64'd0, mag} << 48;
                    q = num / prod;
                    qc = (q > (128'd1 << 47)) ? (64'd1 << 47) : q[63:0];
                    cosv = (dot_acc < 0) ? -$signed(qc) : $signed(qc);
                    dist_val = clamp48((64'sd1 <<< 24) - cosv, f);
                end
            end
        endcase
        if (zero)
        begin
            dist_val = 64'sd0;
            res.status = STATUS_ZERO;
        end
        if (f)
            res.status = STATUS_OVF;
        res.distance = dist_val[47:0];
        dot_acc = 0;
        diff_acc = 0;
        sq_a_acc = 0;
        sq_b_acc = 0;
        pair_count = 0;
        sticky_ovf = 1'b0;
        return 1'b1;
    endfunction

    // observe both channels at each edge
    always @(posedge clk)
    begin
        vdu_result_t   res;
        vdu_result_t   want;
        typed_result_t tr;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            tr = typed_q.pop_front();
            if (accumulate_pair(in_ch.elem_a, in_ch.elem_b, in_ch.last, res))
            begin
                if (tr.typed)
                begin
                    res.distance = tr.distance;
                    res.status = tr.status;
                end
                distance_q.push_back(res);
            end
        end
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            results_seen++;
            if (distance_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result distance %0d status %0d", $time,
                         out_ch.distance, out_ch.status);
            end
            else
            begin
                want = distance_q.pop_front();
                if (out_ch.distance !== want.distance)
                begin
                    errors++;
                    $display("%0t: distance expected %0d actual %0d", $time,
                             want.distance, out_ch.distance);
                end
                if (out_ch.status !== want.status)
                begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, out_ch.status);
                end
            end
        end
    end

    // receiver: random stalls, plus long hold-offs on request
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_cycles > 0)
            begin
                stall_cycles--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    // wait until the last accepted pair is booked, then for all results
    task automatic wait_drained();
        @(posedge clk);
        while (distance_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [24:0] val);
        in_ch.valid <= 1'b0;
        wait_drained();
        repeat (250) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_METRIC_MODE)
            metric_sel = metric_t'(val[1:0]);
        else
            zero_thr = val;
    endtask

    // offer one pair and hold it until the transaction completes
    task automatic send_pair(input logic signed [15:0] a, input logic signed [15:0] b,
                             input bit l, input typed_result_t tr);
        while ($urandom_range(99) < send_idle)
        begin
            in_ch.valid <= 1'b0;
            in_ch.elem_a <= 16'($urandom);
            in_ch.elem_b <= 16'($urandom);
            in_ch.last <= 1'($urandom);
            @(posedge clk);
        end
        typed_q.push_back(tr);
        in_ch.valid <= 1'b1;
        in_ch.elem_a <= a;
        in_ch.elem_b <= b;
        in_ch.last <= l;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    function automatic logic signed [15:0] rand_elem();
        case ($urandom_range(5))
            0:       return 16'sh7FFF;
            1:       return -16'sh8000;
            2:       return $signed(16'($urandom_range(0, 255))) - 16'sd128;
            3:       return $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_vector(input int len);
        typed_result_t none;
        none = '{typed: 1'b0, distance: '0, status: STATUS_OK};
        for (int i = 0; i < len; i++)
            send_pair(rand_elem(), rand_elem(), i == len - 1, none);
    endtask

    function automatic int rand_len();
        if ($urandom_range(19) == 0)
            return $urandom_range(17, 64);
        return $urandom_range(1, 16);
    endfunction

    function automatic logic [24:0] rand_thr();
        case ($urandom_range(3))
            0:       return 25'd0;
            1:       return 25'd168;
            2:       return 25'd16777216;
            default: return 25'($urandom_range(0, 16777216));
        endcase
    endfunction

    initial
    begin
        stim_row_t     rows[$];
        typed_result_t tr;
        int            target;

        rst_n = 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.elem_a <= '0;
        in_ch.elem_b <= '0;
        in_ch.last <= 1'b0;
        dot_acc = 0;
        diff_acc = 0;
        sq_a_acc = 0;
        sq_b_acc = 0;
        pair_count = 0;
        sticky_ovf = 1'b0;
        metric_sel = METRIC_L2SQ;
        zero_thr = 25'd168;
        errors = 0;
        results_seen = 0;
        items_sent = 0;
        send_idle = 0;
        recv_stall = 0;
        stall_cycles = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table; expected values typed where obvious
        rows = '{
            '{0, 0, 0,  16'sd4096,     16'sd0,     1, 1, 48'sd16777216, STATUS_OK},
            '{0, 0, 0,  16'sh7FFF,    -16'sh8000,  1, 1, 48'sd4294836225, STATUS_OK},
            '{0, 0, 0, -16'sh8000,    -16'sh8000,  1, 1, 48'sd0, STATUS_OK},
            '{1, REG_METRIC_MODE, METRIC_IP, 0, 0, 0, 0, 0, STATUS_OK},
            '{0, 0, 0, -16'sh8000,     16'sh7FFF,  1, 1, -48'sd1073709056, STATUS_OK},
            '{0, 0, 0,  16'sd4096,     16'sd4096,  0, 0, 0, STATUS_OK},
            '{0, 0, 0,  16'sd4096,    -16'sd4096,  1, 1, 48'sd0, STATUS_OK},
            '{1, REG_METRIC_MODE, METRIC_L2_NORM, 0, 0, 0, 0, 0, STATUS_OK},
            '{0, 0, 0,  16'sd0,        16'sd0,     1, 1, 48'sd0, STATUS_ZERO},
            '{0, 0, 0,  16'sd4096,     16'sd0,     1, 1, 48'sd0, STATUS_ZERO},
            '{0, 0, 0,  16'sd4096,     16'sd4096,  1, 1, 48'sd0, STATUS_OK},
            '{0, 0, 0,  16'sh7FFF,    -16'sh8000,  1, 0, 0, STATUS_OK},
            '{1, REG_METRIC_MODE, METRIC_COSINE, 0, 0, 0, 0, 0, STATUS_OK},
            '{0, 0, 0,  16'sd0,        16'sd0,     1, 1, 48'sd0, STATUS_ZERO},
            '{0, 0, 0,  16'sd4096,     16'sd4096,  1, 1, 48'sd0, STATUS_OK},
            '{0, 0, 0,  16'sd4096,    -16'sd4096,  1, 1, 48'sd33554432, STATUS_OK},
            '{0, 0, 0,  16'sd1,        16'sd1,     1, 0, 0, STATUS_OK},
            '{1, REG_ZERO_THR, 25'd0, 0, 0, 0, 0, 0, STATUS_OK},
            '{0, 0, 0,  16'sd1,       -16'sd1,     1, 0, 0, STATUS_OK},
            '{0, 0, 0,  16'sd0,        16'sd5,     1, 1, 48'sd0, STATUS_ZERO},
            '{1, REG_ZERO_THR, 25'd16777216, 0, 0, 0, 0, 0, STATUS_OK},
            '{0, 0, 0,  16'sd4096,     16'sd4096,  1, 1, 48'sd0, STATUS_OK},
            '{0, 0, 0,  16'sd2048,     16'sd2048,  1, 1, 48'sd0, STATUS_ZERO}
        };
        foreach (rows[i])
        begin
            if (rows[i].do_cfg)
                write_reg(rows[i].cfg_idx, rows[i].cfg_val);
            else
            begin
                tr = '{typed: rows[i].typed, distance: rows[i].distance, status: rows[i].status};
                send_pair(rows[i].a, rows[i].b, rows[i].last, tr);
            end
        end

        // random phases: idling profile by phase, every metric in each
        target = 1300;
        for (int p = 0; p < 4; p++)
        begin
            send_idle = (p == 1 || p == 3) ? ((p == 1) ? 77 : 28) : 0;
            recv_stall = (p == 2 || p == 3) ? ((p == 2) ? 77 : 28) : 0;
            for (int m = 0; m < 4; m++)
            begin
                write_reg(REG_METRIC_MODE, 25'(m));
                write_reg(REG_ZERO_THR, rand_thr());
                // hold the receiver off while the sender keeps offering
                if (p == 0 && m == 3)
                    stall_cycles = 2000;
                target = items_sent + 80;
                while (items_sent < target)
                    send_vector(rand_len());
            end
        end
        in_ch.valid <= 1'b0;

        // drain
        wait_drained();
        repeat (300) @(posedge clk);
        $display("Covered %0d element pairs and %0d distances over all metrics,", items_sent,
                 results_seen);
        $display("varied thresholds, extreme elements and several idling profiles.");
        if (errors == 0 && distance_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
